### rtl/core/cff_pkg.sv
// ----------------------------------------------------------------------------
// cff_pkg
// Shared widths, codes and controller/datapath interface types for the
// clamped FIR filter.
// ----------------------------------------------------------------------------
package cff_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int FILT_W   = 36;
    localparam int TIDX_W   = 4;
    localparam int LIMIT_W  = 15;
    localparam int TIU_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;
    localparam logic [TIU_W-1:0]   TIU_RESET   = 5'd16;

    localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
    localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic coef_wr;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic issue_last;
        logic pipe_empty;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/cff_ctrl.sv
// ----------------------------------------------------------------------------
// cff_ctrl
// Sequencer: accepts a transaction, steps the multiply-accumulate over the
// taps in use, drains the datapath and hands the sum to the output register.
// ----------------------------------------------------------------------------
module cff_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    input  cff_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output cff_pkg::t_dp_cmd  o_cmd
);
    import cff_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.start    = 1'b0;
        o_cmd.coef_wr  = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_SAMPLE) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_MAC;
                    end else begin
                        o_cmd.coef_wr = 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/cff_datapath.sv
// ----------------------------------------------------------------------------
// cff_datapath
// Configuration registers, coefficient and delay-line memories, one shared
// multiplier, accumulator, saturation and the output register.
// ----------------------------------------------------------------------------
module cff_datapath #(
    parameter int TAPS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_valid,
    input  logic [cff_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [cff_pkg::CFG_DATA_W-1:0]            i_cfg_data,
    input  logic [cff_pkg::TIDX_W-1:0]                i_tap_index,
    input  logic signed [cff_pkg::SAMPLE_W-1:0]       i_value,
    input  cff_pkg::t_dp_cmd                          i_cmd,
    output cff_pkg::t_dp_sts                          o_sts,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [cff_pkg::FILT_W-1:0]         o_filtered
);
    import cff_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int NW    = $clog2(TAPS + 1);
    localparam int SUM_W = PROD_W + 1 + $clog2(TAPS + 1);
    localparam int ACC_W = (SUM_W > FILT_W) ? SUM_W : FILT_W;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(FILT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(FILT_MIN);

    logic [LIMIT_W-1:0]               r_clamp_limit;
    logic [TIU_W-1:0]                 r_taps_in_use;
    logic signed [SAMPLE_W-1:0]       r_c_mem [TAPS];
    logic signed [SAMPLE_W-1:0]       r_d_mem [TAPS];
    logic [TAPS-1:0]                  r_c_vld;
    logic [TAPS-1:0]                  r_d_vld;
    logic [AW-1:0]                    r_wp;
    logic [AW-1:0]                    r_i;
    logic [AW-1:0]                    r_j;
    logic [NW-1:0]                    r_n;
    logic signed [SAMPLE_W-1:0]       r_rd_c;
    logic signed [SAMPLE_W-1:0]       r_rd_d;
    logic                             r_rd_vld;
    logic signed [PROD_W-1:0]         r_prod;
    logic                             r_prod_vld;
    logic signed [ACC_W-1:0]          r_acc;
    logic                             r_out_valid;
    logic signed [FILT_W-1:0]         r_filtered;

    logic [NW-1:0]                    w_n;
    logic [AW-1:0]                    w_wp_eff;
    logic [AW-1:0]                    w_wp_next;
    logic [AW-1:0]                    w_last;
    logic signed [SAMPLE_W-1:0]       w_lim;
    logic signed [SAMPLE_W-1:0]       w_clamped;
    logic signed [ACC_W-1:0]          w_sat;

    always_comb begin
        if (r_taps_in_use == '0) begin
            w_n = NW'(1);
        end else if (32'(r_taps_in_use) > TAPS) begin
            w_n = NW'(TAPS);
        end else begin
            w_n = NW'(r_taps_in_use);
        end
    end

    assign w_wp_eff  = (32'(r_wp) >= 32'(w_n)) ? '0 : r_wp;
    assign w_wp_next = (32'(w_wp_eff) + 1 >= 32'(w_n)) ? '0 : w_wp_eff + 1'b1;
    assign w_last    = AW'(r_n - 1'b1);

    assign w_lim = $signed({1'b0, r_clamp_limit});
    always_comb begin
        if (i_value > w_lim) begin
            w_clamped = w_lim;
        end else if (i_value < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = i_value;
        end
    end

    always_comb begin
        if (r_acc > SAT_MAX) begin
            w_sat = SAT_MAX;
        end else if (r_acc < SAT_MIN) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = r_acc;
        end
    end

    assign o_sts.issue_last = (r_i == w_last);
    assign o_sts.pipe_empty = !r_rd_vld && !r_prod_vld;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_filtered       = r_filtered;

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && (32'(i_tap_index) < TAPS)) begin
            r_c_mem[AW'(i_tap_index)] <= i_value;
        end
        if (i_cmd.start) begin
            r_d_mem[w_wp_eff] <= w_clamped;
        end
        r_rd_c <= r_c_vld[r_i] ? r_c_mem[r_i] : '0;
        r_rd_d <= r_d_vld[r_j] ? r_d_mem[r_j] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit <= LIMIT_RESET;
            r_taps_in_use <= TIU_RESET;
            r_c_vld       <= '0;
            r_d_vld       <= '0;
            r_wp          <= '0;
            r_rd_vld      <= 1'b0;
            r_prod_vld    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLAMP_LIMIT: r_clamp_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_TAPS_IN_USE: r_taps_in_use <= i_cfg_data[TIU_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.coef_wr && (32'(i_tap_index) < TAPS)) begin
                r_c_vld[AW'(i_tap_index)] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_d_vld[w_wp_eff] <= 1'b1;
                r_wp              <= w_wp_next;
            end
            r_rd_vld   <= i_cmd.issue;
            r_prod_vld <= r_rd_vld;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_i   <= '0;
            r_j   <= w_wp_eff;
            r_n   <= w_n;
            r_acc <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_i <= r_i + 1'b1;
                r_j <= (r_j == w_last) ? '0 : r_j + 1'b1;
            end
            if (r_prod_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (r_rd_vld) begin
            r_prod <= PROD_W'(r_rd_c) * PROD_W'(r_rd_d);
        end
        if (i_cmd.load_out) begin
            r_filtered <= FILT_W'(w_sat);
        end
    end

endmodule

### rtl/core/clamped_fir_filter.sv
// ----------------------------------------------------------------------------
// clamped_fir_filter
// FIR filter over a ring-buffer delay line with input clamping.
//
// Input channel (i_in_valid/o_in_ready): a command 0 transaction clamps
// i_value to +/- clamp_limit, stores it in the delay line and yields one
// result on o_filtered (Q.30, saturated to 36 bits). A command 1 transaction
// writes coefficient i_tap_index and yields nothing; the input stays ready.
// Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; index 0
// is clamp_limit, index 1 is taps_in_use. Write it only while idle.
// A sample keeps the input busy while the pass walks n taps, n being
// taps_in_use held to 1..TAPS; the result appears in the output register
// in the same cycle that the input is ready again. One shared multiplier walks
// the taps one per cycle through the registered memory read, product and add.
// A finished result waits in the output register while the next transaction
// is accepted; if the receiver still stalls, the next result holds in the
// accumulator. Reset clears the delay line, coefficients and write position,
// restores the default configuration; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module clamped_fir_filter #(
    parameter int TAPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [cff_pkg::TIDX_W-1:0]            i_tap_index,
    input  logic signed [cff_pkg::SAMPLE_W-1:0]   i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [cff_pkg::FILT_W-1:0]     o_filtered,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cff_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cff_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cff_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    cff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    cff_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered)
    );

endmodule

### rtl/core/cff_checker.sv
// ----------------------------------------------------------------------------
// cff_checker
// Port-level checks on sequencing and output behavior of the filter.
// ----------------------------------------------------------------------------
module cff_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [cff_pkg::FILT_W-1:0]     o_filtered
);
    import cff_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered))
        else $error("output transaction dropped or changed while stalled");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_SAMPLE) |=> !o_in_ready)
        else $error("sample transaction did not start a filter pass");

    a_coef_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_COEF) |=> o_in_ready)
        else $error("coefficient transaction stalled the input");

    a_out_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a filter pass");

endmodule

bind clamped_fir_filter cff_checker u_cff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_filtered  (o_filtered)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clamped FIR filter. Drives sample and
// coefficient transactions with random idle gaps and output stalls. Predicts
// each filtered result from a local copy of the delay line, coefficients,
// write position and configuration, then compares results in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cff_pkg::*;

    localparam int TAPS = 16;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_command;
    logic [TIDX_W-1:0]             i_tap_index;
    logic signed [SAMPLE_W-1:0]    i_value;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [FILT_W-1:0]      o_filtered;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    logic signed [SAMPLE_W-1:0]    ring_model [TAPS];
    logic signed [SAMPLE_W-1:0]    coef_model [TAPS];
    int                            ring_pos;
    logic [LIMIT_W-1:0]            limit_model;
    logic [TIU_W-1:0]              taps_model;

    logic signed [FILT_W-1:0]      filtered_expect_q [$];
    logic signed [FILT_W-1:0]      filtered_want;

    bit                            send_idle_on;
    bit                            recv_stall_on;
    int                            recv_hold_cycles;

    int                            mismatch_count;
    int                            checked_count;
    int                            sample_count;
    int                            coef_count;
    int                            config_count;

    clamped_fir_filter #(
        .TAPS(TAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_tap_index (i_tap_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void predict_filter(input logic cmd, input logic [TIDX_W-1:0] idx,
                                           input logic signed [SAMPLE_W-1:0] val);
        int     n;
        int     s;
        int     lim;
        int     pos;
        longint acc;
        if (cmd == CMD_COEF) begin
            coef_model[idx] = val;
            coef_count++;
            return;
        end
        s   = int'(val);
        lim = int'(limit_model);
        if (s > lim) begin
            s = lim;
        end else if (s < -lim) begin
            s = -lim;
        end
        n = (taps_model == '0) ? 1 : (int'(taps_model) > TAPS) ? TAPS : int'(taps_model);
        if (ring_pos >= n) begin
            ring_pos = 0;
        end
        ring_model[ring_pos] = SAMPLE_W'(s);
        acc = 0;
        pos = ring_pos;
        for (int i = 0; i < n; i++) begin
            acc += longint'(coef_model[i]) * longint'(ring_model[pos]);
            pos = (pos + 1 >= n) ? 0 : pos + 1;
        end
        ring_pos = (ring_pos + 1 >= n) ? 0 : ring_pos + 1;
        if (acc > longint'(FILT_MAX)) begin
            acc = longint'(FILT_MAX);
        end else if (acc < longint'(FILT_MIN)) begin
            acc = longint'(FILT_MIN);
        end
        filtered_expect_q.push_back(FILT_W'(acc));
        sample_count++;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_value();
        int v;
        case ($urandom_range(0, 7))
            0: begin
                return {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            1: begin
                return {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            2: begin
                v = int'(limit_model) + int'($urandom_range(0, 2)) - 1;
                return SAMPLE_W'($urandom_range(0, 1) ? v : -v);
            end
            default: begin
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    // hold valid across back-to-back transactions; lowered by the next gap or by wait_idle
    task automatic send_item(input logic cmd, input logic [TIDX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] val);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_tap_index <= idx;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_filter(cmd, idx, val);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (filtered_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAPS + 8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic [TIU_W-1:0] taps);
        logic [CFG_DATA_W-1:0] data;
        data              = CFG_DATA_W'($urandom);
        data[TIU_W-1:0]   = taps;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CLAMP_LIMIT;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_model = limit;
        i_cfg_index <= CFG_TAPS_IN_USE;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        taps_model = taps;
        i_cfg_valid <= 1'b0;
        config_count++;
    endtask

    task automatic test_coefficient_extremes();
        set_config(LIMIT_RESET, TIU_RESET);
        send_item(CMD_COEF, 4'd0, 16'sh7FFF);
        send_item(CMD_COEF, 4'd1, 16'sh8000);
        send_item(CMD_COEF, 4'd15, -16'sd1);
        send_item(CMD_COEF, 4'd7, 16'sd1);
        send_item(CMD_SAMPLE, 4'd0, 16'sh7FFF);
        send_item(CMD_SAMPLE, 4'd15, 16'sh8000);
        send_item(CMD_SAMPLE, 4'd5, -16'sd1);
        send_item(CMD_SAMPLE, 4'd10, 16'sd0);
    endtask

    task automatic test_clamp_limit();
        wait_idle();
        set_config(15'd0, TIU_RESET);
        send_item(CMD_SAMPLE, 4'd0, 16'sh7FFF);
        send_item(CMD_SAMPLE, 4'd0, 16'sh8000);
        wait_idle();
        set_config(15'd1, TIU_RESET);
        send_item(CMD_SAMPLE, 4'd0, 16'sh7FFF);
        send_item(CMD_SAMPLE, 4'd0, 16'sh8000);
        wait_idle();
        set_config(15'd1000, TIU_RESET);
        send_item(CMD_SAMPLE, 4'd0, 16'sd1234);
        send_item(CMD_SAMPLE, 4'd0, -16'sd1234);
    endtask

    task automatic test_tap_count();
        wait_idle();
        set_config(LIMIT_RESET, 5'd0);
        send_item(CMD_SAMPLE, 4'd0, 16'sd100);
        send_item(CMD_SAMPLE, 4'd0, -16'sd200);
        wait_idle();
        set_config(LIMIT_RESET, 5'd31);
        send_item(CMD_SAMPLE, 4'd0, 16'sd3);
        send_item(CMD_SAMPLE, 4'd0, 16'sd5);
        wait_idle();
        set_config(LIMIT_RESET, 5'd16);
        send_item(CMD_SAMPLE, 4'd0, 16'sd7);
        send_item(CMD_SAMPLE, 4'd0, 16'sd8);
        send_item(CMD_SAMPLE, 4'd0, 16'sd9);
        // shrink the ring below the write position
        wait_idle();
        set_config(LIMIT_RESET, 5'd2);
        send_item(CMD_SAMPLE, 4'd0, 16'sd11);
    endtask

    task automatic test_random_traffic(input int phases, input int items_per_phase);
        logic [LIMIT_W-1:0] limit;
        logic [TIU_W-1:0]   taps;
        for (int phase = 0; phase < phases; phase++) begin
            case (phase)
                0: begin
                    limit = LIMIT_RESET;
                    taps  = TIU_RESET;
                end
                1: begin
                    limit = '0;
                    taps  = 5'd31;
                end
                2: begin
                    limit = 15'd1;
                    taps  = 5'd0;
                end
                3: begin
                    limit = LIMIT_RESET;
                    taps  = 5'd1;
                end
                default: begin
                    limit = $urandom_range(0, 1) ? LIMIT_W'($urandom)
                                                 : LIMIT_W'($urandom_range(0, 300));
                    taps  = TIU_W'($urandom_range(0, 31));
                end
            endcase
            wait_idle();
            set_config(limit, taps);
            send_idle_on  = (phase % 3 != 0);
            recv_stall_on = (phase % 4 != 0);
            for (int k = 0; k < items_per_phase; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_item(CMD_COEF, TIDX_W'($urandom), rand_value());
                end else begin
                    send_item(CMD_SAMPLE, TIDX_W'($urandom), rand_value());
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        set_config(LIMIT_RESET, TIU_RESET);
        send_idle_on     = 1'b0;
        recv_stall_on    = 1'b0;
        recv_hold_cycles = 300;
        for (int k = 0; k < 24; k++) begin
            send_item(CMD_SAMPLE, TIDX_W'($urandom), rand_value());
        end
    endtask

    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = recv_hold_cycles + (recv_stall_on ? int'($urandom_range(0, 11)) : 0);
            recv_hold_cycles = 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid && recv_hold_cycles == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_expect_q.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %0d",
                         $time, o_filtered);
                mismatch_count++;
            end else begin
                filtered_want = filtered_expect_q.pop_front();
                checked_count++;
                if (o_filtered !== filtered_want) begin
                    $display("%0t: filtered mismatch: expected %0d, actual %0d",
                             $time, filtered_want, o_filtered);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = CMD_SAMPLE;
        i_tap_index      = '0;
        i_value          = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_CLAMP_LIMIT;
        i_cfg_data       = '0;
        send_idle_on     = 1'b1;
        recv_stall_on    = 1'b1;
        recv_hold_cycles = 0;
        mismatch_count   = 0;
        checked_count    = 0;
        sample_count     = 0;
        coef_count       = 0;
        config_count     = 0;
        for (int i = 0; i < TAPS; i++) begin
            ring_model[i] = '0;
            coef_model[i] = '0;
        end
        ring_pos    = 0;
        limit_model = LIMIT_RESET;
        taps_model  = TIU_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_coefficient_extremes();
        test_clamp_limit();
        test_tap_count();
        test_output_backpressure();
        test_random_traffic(9, 110);
        wait_idle();

        $display("Run covered %0d samples, %0d coefficient writes, %0d configurations.",
                 sample_count, coef_count, config_count);
        $display("Checked %0d filtered results, including a long output stall.",
                 checked_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
